>>> hdl/bitplane_pixel_plot_engine_top_macros.svh
// ---------------------------------------------------------------------------
// bitplane pixel plot engine assertion macros
// shared property forms for the engine's concurrent checks
// ---------------------------------------------------------------------------
`ifndef BITPLANE_PIXEL_PLOT_ENGINE_TOP_MACROS_SVH
`define BITPLANE_PIXEL_PLOT_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPPE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bppe assertion failed");

// next-cycle implication, disabled during reset
`define BPPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bppe assertion failed");

`endif

>>> hdl/bppe_pkg.sv
// ---------------------------------------------------------------------------
// bppe_pkg
// sizes, codes and control types of the bitplane pixel plot engine
// ---------------------------------------------------------------------------
`default_nettype none

package bppe_pkg;

	// framebuffer geometry
	localparam int PLANES     = 4;
	localparam int MAX_WIDTH  = 320;
	localparam int MAX_HEIGHT = 200;
	localparam int GROUP_PX   = 16;
	localparam int WORD_W     = 16;

	// field widths
	localparam int COORD_W = 16;
	localparam int COLOR_W = 4;
	localparam int CFG_W   = 9;
	localparam int HGT_W   = 8;
	localparam int IDX_W   = 1;

	// register reset values
	localparam int RST_WIDTH  = 320;
	localparam int RST_HEIGHT = 200;

	// derived sizes
	localparam int GROUPS_MAX   = MAX_WIDTH / GROUP_PX;
	localparam int DEPTH        = GROUPS_MAX * MAX_HEIGHT;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int ROW_W        = PLANES * WORD_W;
	localparam int XW           = $clog2(MAX_WIDTH + 1);
	localparam int YW           = $clog2(MAX_HEIGHT + 1);
	localparam int LIM_W        = (XW > YW) ? XW : YW;
	localparam int GRP_W        = XW - 4;
	localparam int PROD_W       = YW + GRP_W;
	localparam int USED_PLANES  = (PLANES < COLOR_W) ? PLANES : COLOR_W;
	localparam int RST_EFF_W    =
		(((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH) / GROUP_PX) * GROUP_PX;
	localparam int RST_EFF_H    = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 1'b1;

	// operation codes
	typedef enum logic [1:0] {
		OP_PLOT = 2'd0,
		OP_READ = 2'd1,
		OP_HRUN = 2'd2,
		OP_VRUN = 2'd3
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic clr;
		logic latch;
		logic setup;
		logic rd;
		logic wr;
		logic step;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic active;
		logic is_read;
		logic last_px;
		logic clr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/bitplane_pixel_plot_engine_top.sv
// ---------------------------------------------------------------------------
// bitplane_pixel_plot_engine_top
// pixel plot, pixel read and clipped run drawing over an interleaved
// four-plane framebuffer
// ---------------------------------------------------------------------------
// After reset the engine clears its framebuffer memory, one group of plane
// words per cycle, and takes no item until that is done; configuration
// writes are taken at any time. Each pixel drawn is a read-modify-write of
// one group over a single memory port with registered read data, a read
// state then a write state. Every accepted item first passes the setup
// state for clipping; a read goes on from its read state to the result
// state, which waits until the result register is free, a read outside the
// bitmap goes there from setup, and a fully clipped plot or run goes idle.
`default_nettype none

module bitplane_pixel_plot_engine_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// items in
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// x_coord[15:0], y_coord[31:16], run_length[47:32], pixel_color[51:48]
	input  wire logic [55:0]                   s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]                    s_tuser,
	// results out
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// read_color[3:0]
	output logic [7:0]                         m_tdata,
	// configuration writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bppe_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [bppe_pkg::CFG_W-1:0]    cfg_data
);
	import bppe_pkg::*;

	ctrl_cmd_t          cmd;
	dp_stat_t           st;
	logic [COLOR_W-1:0] out_color;

	assign cfg_ready = 1'b1;

	// sequencer
	bppe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	// clipping, memory and registers
	bppe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.in_op     (s_tuser),
		.in_x      (s_tdata[15:0]),
		.in_y      (s_tdata[31:16]),
		.in_len    (s_tdata[47:32]),
		.in_color  (s_tdata[51:48]),
		.out_color (out_color)
	);

	assign m_tdata = {4'b0, out_color};

endmodule

`default_nettype wire

>>> hdl/bppe_dp.sv
// ---------------------------------------------------------------------------
// bppe_dp
// clipping, address generation, group memory with read-modify-write,
// configuration registers and result register
// ---------------------------------------------------------------------------
`default_nettype none

module bppe_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bppe_pkg::ctrl_cmd_t               cmd,
	output bppe_pkg::dp_stat_t                     st,
	input  wire logic                              cfg_we,
	input  wire logic [bppe_pkg::IDX_W-1:0]        cfg_idx,
	input  wire logic [bppe_pkg::CFG_W-1:0]        cfg_val,
	input  wire logic [1:0]                        in_op,
	input  wire logic [bppe_pkg::COORD_W-1:0]      in_x,
	input  wire logic [bppe_pkg::COORD_W-1:0]      in_y,
	input  wire logic [bppe_pkg::COORD_W-1:0]      in_len,
	input  wire logic [bppe_pkg::COLOR_W-1:0]      in_color,
	output logic [bppe_pkg::COLOR_W-1:0]           out_color
);
	import bppe_pkg::*;

	// effective width and height, kept already clamped
	logic [XW-1:0]      eff_w_q;
	logic [YW-1:0]      eff_h_q;
	logic [XW-1:0]      w_clamp;
	logic [YW-1:0]      h_clamp;

	// latched item
	op_t                op_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COORD_W-1:0] len_q;
	logic [COLOR_W-1:0] color_q;

	// clipping terms
	logic signed [16:0] x17;
	logic signed [16:0] y17;
	logic signed [16:0] ew17;
	logic signed [16:0] eh17;
	logic signed [16:0] xp1;
	logic [COORD_W-1:0] hsum;
	logic [COORD_W-1:0] vsum;
	logic signed [16:0] hend_raw;
	logic signed [16:0] vend_raw;
	logic signed [16:0] hstart;
	logic signed [16:0] vstart;
	logic signed [16:0] hend;
	logic signed [16:0] vend;
	logic               len_pos;
	logic               x_in;
	logic               y_in;
	logic               act_n;
	logic [XW-1:0]      px_n;
	logic [YW-1:0]      py_n;
	logic [LIM_W-1:0]   lim_n;
	logic               horiz_n;

	// pixel walk
	logic               active_q;
	logic               horiz_q;
	logic [XW-1:0]      px_q;
	logic [YW-1:0]      py_q;
	logic [LIM_W-1:0]   lim_q;
	logic [LIM_W:0]     nxt_h;
	logic [LIM_W:0]     nxt_v;

	// memory side
	logic [ROW_W-1:0]   mem [DEPTH];
	logic [ROW_W-1:0]   rdata_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  addr_full;
	logic [ADDR_W-1:0]  addr_c;
	logic [ROW_W-1:0]   wdata;
	logic [WORD_W-1:0]  mask;
	logic [PLANES+COLOR_W-1:0] cext;
	logic [COLOR_W-1:0] rd_color;
	logic [COLOR_W-1:0] out_q;

	// configuration clamps
	always_comb begin
		if (32'(cfg_val) > 32'(MAX_WIDTH)) begin
			w_clamp = XW'(MAX_WIDTH);
		end else begin
			w_clamp = XW'(cfg_val);
		end
		w_clamp[3:0] = 4'b0;
		if (32'(cfg_val[HGT_W-1:0]) > 32'(MAX_HEIGHT)) begin
			h_clamp = YW'(MAX_HEIGHT);
		end else begin
			h_clamp = YW'(cfg_val[HGT_W-1:0]);
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= XW'(RST_EFF_W);
			eff_h_q <= YW'(RST_EFF_H);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH:  eff_w_q <= w_clamp;
				REG_HEIGHT: eff_h_q <= h_clamp;
			endcase
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op_t'(in_op);
			x_q     <= in_x;
			y_q     <= in_y;
			len_q   <= in_len;
			color_q <= in_color;
		end
	end

	// clipping of point and runs
	always_comb begin
		x17      = $signed({x_q[COORD_W-1], x_q});
		y17      = $signed({y_q[COORD_W-1], y_q});
		ew17     = $signed(17'(eff_w_q));
		eh17     = $signed(17'(eff_h_q));
		xp1      = x17 + 17'sd1;
		hsum     = x_q + len_q;
		vsum     = y_q + len_q;
		hend_raw = $signed({hsum[COORD_W-1], hsum});
		vend_raw = $signed({vsum[COORD_W-1], vsum});
		hstart   = x_q[COORD_W-1] ? 17'sd0 : x17;
		vstart   = y_q[COORD_W-1] ? 17'sd0 : y17;
		hend     = (hend_raw > ew17) ? ew17 : hend_raw;
		vend     = (vend_raw > eh17) ? eh17 : vend_raw;
		len_pos  = !len_q[COORD_W-1] && (len_q != '0);
		x_in     = !x_q[COORD_W-1] && (x17 < ew17);
		y_in     = !y_q[COORD_W-1] && (y17 < eh17);
		unique case (op_q)
			OP_PLOT, OP_READ: begin
				act_n   = x_in && y_in;
				px_n    = x17[XW-1:0];
				py_n    = y17[YW-1:0];
				lim_n   = xp1[LIM_W-1:0];
				horiz_n = 1'b1;
			end
			OP_HRUN: begin
				act_n   = y_in && len_pos && (hstart < hend);
				px_n    = hstart[XW-1:0];
				py_n    = y17[YW-1:0];
				lim_n   = hend[LIM_W-1:0];
				horiz_n = 1'b1;
			end
			OP_VRUN: begin
				act_n   = x_in && len_pos && (vstart < vend);
				px_n    = x17[XW-1:0];
				py_n    = vstart[YW-1:0];
				lim_n   = vend[LIM_W-1:0];
				horiz_n = 1'b0;
			end
		endcase
	end

	// pixel cursor
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			active_q <= act_n;
			horiz_q  <= horiz_n;
			px_q     <= px_n;
			py_q     <= py_n;
			lim_q    <= lim_n;
		end else if (cmd.step) begin
			if (horiz_q) begin
				px_q <= px_q + XW'(1);
			end else begin
				py_q <= py_q + YW'(1);
			end
		end
	end

	// end of run
	always_comb begin
		nxt_h = (LIM_W+1)'(px_q) + (LIM_W+1)'(1);
		nxt_v = (LIM_W+1)'(py_q) + (LIM_W+1)'(1);
	end

	// group address: row times groups per row plus group
	always_comb begin
		prod      = PROD_W'(py_q) * PROD_W'(eff_w_q[XW-1:4]);
		addr_full = prod + PROD_W'(px_q[XW-1:4]);
		addr_c    = ADDR_W'(addr_full);
	end

	// plane update and readback
	always_comb begin
		mask     = {1'b1, {(WORD_W-1){1'b0}}} >> px_q[3:0];
		cext     = (PLANES+COLOR_W)'(color_q);
		rd_color = '0;
		for (int p = 0; p < PLANES; p++) begin
			if (cext[p]) begin
				wdata[p*WORD_W +: WORD_W] = rdata_q[p*WORD_W +: WORD_W] | mask;
			end else begin
				wdata[p*WORD_W +: WORD_W] = rdata_q[p*WORD_W +: WORD_W] & ~mask;
			end
		end
		for (int p = 0; p < USED_PLANES; p++) begin
			rd_color[p] = |(rdata_q[p*WORD_W +: WORD_W] & mask);
		end
	end

	// clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// group memory, one row of plane words per address
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr) begin
			mem[addr_q] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr_c];
			addr_q  <= addr_c;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= active_q ? rd_color : '0;
		end
	end

	// status
	always_comb begin
		st.active   = act_n;
		st.is_read  = (op_q == OP_READ);
		st.last_px  = horiz_q ? (nxt_h >= (LIM_W+1)'(lim_q))
		                      : (nxt_v >= (LIM_W+1)'(lim_q));
		st.clr_last = (clr_q == ADDR_W'(DEPTH - 1));
	end

	assign out_color = out_q;

endmodule

`default_nettype wire

>>> hdl/bppe_ctrl.sv
// ---------------------------------------------------------------------------
// bppe_ctrl
// sequencer: clearing pass, item intake, read-modify-write per pixel,
// result handoff
// ---------------------------------------------------------------------------
`default_nettype none

`include "bitplane_pixel_plot_engine_top_macros.svh"

module bppe_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output bppe_pkg::ctrl_cmd_t        cmd,
	input  wire bppe_pkg::dp_stat_t    st
);
	import bppe_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SETUP,
		S_READ,
		S_WRITE,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

	// commands decoded from state
	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == S_CLEAR);
		cmd.latch    = (state_q == S_IDLE) && s_tvalid;
		cmd.setup    = (state_q == S_SETUP);
		cmd.rd       = (state_q == S_READ);
		cmd.wr       = (state_q == S_WRITE);
		cmd.step     = (state_q == S_WRITE) && !st.last_px;
		cmd.load_out = (state_q == S_RESULT) && out_free;
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == S_RESULT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (st.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) state_q <= S_SETUP;
				end
				S_SETUP: begin
					if (st.active) begin
						state_q <= S_READ;
					end else if (st.is_read) begin
						state_q <= S_RESULT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					state_q <= st.is_read ? S_RESULT : S_WRITE;
				end
				S_WRITE: begin
					state_q <= st.last_px ? S_IDLE : S_READ;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a write always follows the read of the same group
	`BPPE_ASSERT_IMPL(a_wr_after_rd, clk, arst_n, state_q == S_WRITE, $past(state_q) == S_READ)
	// an accepted item always moves on to clipping
	`BPPE_ASSERT_NEXT(a_accept_setup, clk, arst_n, s_tvalid && s_tready, state_q == S_SETUP)
	// a pending result is never overwritten
	`BPPE_ASSERT_NEXT(a_result_hold, clk, arst_n,
		state_q == S_RESULT && m_tvalid_q && !m_tready, state_q == S_RESULT)
	// no pixel read or write and no item intake while the clearing pass runs
	`BPPE_ASSERT_IMPL(a_clear_excl, clk, arst_n, cmd.clr, !cmd.wr && !cmd.rd && !s_tready)

endmodule

`default_nettype wire

>>> dv/bitplane_pixel_plot_engine_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitplane_pixel_plot_engine_checker
// watches the item, result and register channels, keeps its own copy of the
// interleaved plane store, predicts the colour of every pixel read and
// compares each result item with the oldest prediction
// ---------------------------------------------------------------------------

module bitplane_pixel_plot_engine_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	input  wire logic                               s_tready,
	// x_coord[15:0], y_coord[31:16], run_length[47:32], pixel_color[51:48]
	input  wire logic [55:0]                        s_tdata,
	// opcode[1:0]
	input  wire logic [1:0]                         s_tuser,
	input  wire logic                               m_tvalid,
	input  wire logic                               m_tready,
	// read_color[3:0]
	input  wire logic [7:0]                         m_tdata,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [bppe_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [bppe_pkg::CFG_W-1:0]         cfg_data,
	output int                                      fail_count,
	output int                                      pending
);

	localparam int WORDS = bppe_pkg::DEPTH * bppe_pkg::PLANES;

	// mirror of the framebuffer and of the two size registers
	logic [15:0] plane_words [WORDS];
	logic [8:0]  width_reg;
	logic [7:0]  height_reg;
	logic [3:0]  colors_due [$];

	// clipping bounds as the engine sees them
	function automatic int active_width();
		int w;
		w = width_reg;
		if (w > bppe_pkg::MAX_WIDTH)
			w = bppe_pkg::MAX_WIDTH;
		return w & ~15;
	endfunction

	function automatic int active_height();
		int h;
		h = height_reg;
		if (h > bppe_pkg::MAX_HEIGHT)
			h = bppe_pkg::MAX_HEIGHT;
		return h;
	endfunction

	function automatic bit on_bitmap(input int x, input int y);
		return x >= 0 && y >= 0 && x < active_width() && y < active_height();
	endfunction

	// plane 0 word of the group holding an on-bitmap pixel
	function automatic int group_word(input int x, input int y);
		return (y * (active_width() / 16) + x / 16) * bppe_pkg::PLANES;
	endfunction

	function automatic void paint(input int x, input int y, input logic [3:0] c);
		int base;
		logic [15:0] mask;
		if (!on_bitmap(x, y))
			return;
		base = group_word(x, y);
		mask = 16'h8000 >> (x % 16);
		for (int p = 0; p < bppe_pkg::PLANES; p++) begin
			if (p < 4 && c[p % 4])
				plane_words[base + p] = plane_words[base + p] | mask;
			else
				plane_words[base + p] = plane_words[base + p] & ~mask;
		end
	endfunction

	function automatic logic [3:0] sample(input int x, input int y);
		int base;
		logic [15:0] mask;
		logic [3:0] c;
		c = '0;
		if (!on_bitmap(x, y))
			return c;
		base = group_word(x, y);
		mask = 16'h8000 >> (x % 16);
		for (int p = 0; p < bppe_pkg::PLANES && p < 4; p++) begin
			if ((plane_words[base + p] & mask) != 16'h0)
				c[p] = 1'b1;
		end
		return c;
	endfunction

	// apply one item to the mirror; a read queues the colour it must return
	function automatic void take_item(input bppe_pkg::op_t op, input int x, input int y,
			input int len, input logic [3:0] c);
		int stop;
		int lo;
		case (op)
			bppe_pkg::OP_PLOT: begin
				paint(x, y, c);
			end
			bppe_pkg::OP_READ: begin
				colors_due.push_back(sample(x, y));
			end
			bppe_pkg::OP_HRUN: begin
				if (y >= 0 && y < active_height() && len > 0) begin
					// end wraps at 16 bits before clamping
					stop = int'(shortint'(x + len));
					lo = (x < 0) ? 0 : x;
					if (stop > active_width())
						stop = active_width();
					for (int i = lo; i < stop; i++)
						paint(i, y, c);
				end
			end
			default: begin
				if (x >= 0 && x < active_width() && len > 0) begin
					stop = int'(shortint'(y + len));
					lo = (y < 0) ? 0 : y;
					if (stop > active_height())
						stop = active_height();
					for (int i = lo; i < stop; i++)
						paint(x, i, c);
				end
			end
		endcase
	endfunction

	// results first, then register writes, then new items
	always @(posedge clk or negedge arst_n) begin : watch
		logic [3:0] want;
		if (!arst_n) begin
			foreach (plane_words[i])
				plane_words[i] = '0;
			width_reg = bppe_pkg::RST_WIDTH;
			height_reg = bppe_pkg::RST_HEIGHT;
			colors_due.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (colors_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got read_color %0d",
						$time, m_tdata[3:0]);
					fail_count++;
				end else begin
					want = colors_due.pop_front();
					if (m_tdata[3:0] !== want) begin
						$display("%0t: read_color mismatch, expected %0d, got %0d",
							$time, want, m_tdata[3:0]);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bppe_pkg::REG_WIDTH)
					width_reg = cfg_data[8:0];
				else if (cfg_index == bppe_pkg::REG_HEIGHT)
					height_reg = cfg_data[7:0];
			end
			if (s_tvalid && s_tready)
				take_item(bppe_pkg::op_t'(s_tuser), int'($signed(s_tdata[15:0])),
					int'($signed(s_tdata[31:16])), int'($signed(s_tdata[47:32])),
					s_tdata[51:48]);
		end
		pending = colors_due.size();
	end

endmodule

>>> dv/bitplane_pixel_plot_engine_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitplane_pixel_plot_engine_top_test
// drives plots, reads and clipped runs into the pixel engine over several
// bitmap sizes with random gaps and stalls; the checker predicts and
// compares, this module gives the verdict
// ---------------------------------------------------------------------------

module bitplane_pixel_plot_engine_top_test;

	import bppe_pkg::*;

	localparam int CYCLE_LIMIT  = 6_000_000;
	localparam int DRAIN_CYCLES = 700;
	localparam int HOLD_CYCLES  = 3000;
	localparam int HOLD_AFTER   = 600;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [55:0]         s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	int fail_count;
	int pending;
	int items_sent;
	int lim_w;
	int lim_h;

	bitplane_pixel_plot_engine_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bitplane_pixel_plot_engine_checker pixel_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// coordinates crowd the origin and the far edge, with some full-range values
	function automatic int pick_coord(input int lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return int'($urandom_range(0, 47)) - 4;
		if (r < 80)
			return lim + int'($urandom_range(0, 7)) - 4;
		if (r < 94)
			return int'($urandom_range(0, lim + 1));
		return int'(shortint'($urandom()));
	endfunction

	// short runs mostly, some empty, a few long or wild
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 16);
		if (r < 78)
			return -int'($urandom_range(0, 40));
		if (r < 92)
			return $urandom_range(17, 400);
		return int'(shortint'($urandom()));
	endfunction

	// offer one item and wait until it is taken
	task automatic offer(input op_t op, input int x, input int y, input int len,
			input logic [3:0] c, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, c, len[15:0], y[15:0], x[15:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, let every read come back and the last run finish
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic retune(input int w, input int h);
		settle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		lim_w = ((w > MAX_WIDTH) ? MAX_WIDTH : w) & ~15;
		lim_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
	endtask

	task automatic random_items(input int n);
		int r;
		op_t op;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				op = OP_PLOT;
			else if (r < 60)
				op = OP_READ;
			else if (r < 80)
				op = OP_HRUN;
			else
				op = OP_VRUN;
			offer(op, pick_coord(lim_w), pick_coord(lim_h), pick_len(),
				4'($urandom_range(0, 15)), (k / 64) % 4 == 0);
		end
	endtask

	// corners, clipping, wrapping ends and empty runs on the reset-size bitmap
	task automatic directed_items();
		offer(OP_PLOT, 0, 0, 0, 4'd15, 1'b0);
		offer(OP_READ, 0, 0, 0, 4'd0, 1'b0);
		offer(OP_PLOT, 319, 199, -1, 4'd9, 1'b0);
		offer(OP_READ, 319, 199, 0, 4'd0, 1'b0);
		offer(OP_READ, 320, 199, 0, 4'd0, 1'b0);
		offer(OP_READ, -1, 0, 0, 4'd0, 1'b0);
		offer(OP_READ, 0, 200, 0, 4'd0, 1'b0);
		offer(OP_PLOT, 320, 0, 0, 4'd15, 1'b0);
		offer(OP_READ, -32768, 32767, 32767, 4'd15, 1'b0);
		offer(OP_HRUN, -5, 3, 30, 4'd5, 1'b0);
		offer(OP_READ, 24, 3, 0, 4'd0, 1'b0);
		offer(OP_READ, 25, 3, 0, 4'd0, 1'b0);
		// end wraps negative, nothing drawn
		offer(OP_HRUN, 300, 4, 32767, 4'd10, 1'b0);
		offer(OP_READ, 310, 4, 0, 4'd0, 1'b0);
		offer(OP_HRUN, 300, 5, 100, 4'd6, 1'b0);
		offer(OP_READ, 319, 5, 0, 4'd0, 1'b0);
		offer(OP_HRUN, 0, 6, 0, 4'd3, 1'b0);
		offer(OP_HRUN, 0, 6, -32768, 4'd3, 1'b0);
		offer(OP_VRUN, 7, -3, 10, 4'd12, 1'b0);
		offer(OP_READ, 7, 6, 0, 4'd0, 1'b0);
		offer(OP_READ, 7, 7, 0, 4'd0, 1'b0);
		offer(OP_VRUN, 5, 32767, 1, 4'd4, 1'b0);
		offer(OP_VRUN, 320, 0, 5, 4'd1, 1'b0);
		offer(OP_PLOT, 16, 0, 0, 4'd2, 1'b0);
		offer(OP_READ, 16, 0, 0, 4'd0, 1'b0);
	endtask

	// result side: random stalls, calm windows and one long hold-off
	initial begin
		int stall;
		int rx_cycles;
		bit held;
		stall = 0;
		rx_cycles = 0;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (!held && items_sent >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if ((rx_cycles / 500) % 4 == 3 || $urandom_range(0, 99) < 75) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall = pick_gap();
			end
		end
	end

	// stimulus and verdict
	initial begin
		int sizes_w [7] = '{16, 511, 100, 15, 320, 48, 320};
		int sizes_h [7] = '{1, 255, 37, 200, 0, 200, 200};
		int counts  [7] = '{150, 300, 250, 60, 60, 250, 330};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_PLOT;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		items_sent = 0;
		lim_w = RST_EFF_W;
		lim_h = RST_EFF_H;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_items();
		random_items(300);
		for (int i = 0; i < 7; i++) begin
			retune(sizes_w[i], sizes_h[i]);
			random_items(counts[i]);
		end
		settle();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
